// ===== rtl/complex_number_alu_macros.svh =====
// Assertion macros for the complex number ALU checker
`ifndef COMPLEX_NUMBER_ALU_MACROS_SVH
`define COMPLEX_NUMBER_ALU_MACROS_SVH

// checked only while out of reset
`define CNA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("complex_number_alu assertion failed");

// checked on every edge, reset included
`define CNA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("complex_number_alu assertion failed");

`endif

// ===== rtl/cna_pkg.sv =====
// Shared types, constants and functions for the complex number ALU
package cna_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QB        = 33;
  localparam int NCELL     = QB;
  localparam int DVD_W     = 64 + FRAC_BITS;
  localparam int TOP_W     = DVD_W - QB;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } res_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [QB-1:0] q;
    logic [QB-1:0] lo;
    logic        neg;
    logic        ovf;
  } lane_t;

  typedef struct packed {
    logic        vld;
    logic        is_div;
    logic [31:0] rr;
    logic [31:0] ri;
    status_t     st;
    logic [63:0] den;
    lane_t       re;
    lane_t       im;
  } pipe_t;

  function automatic res_t sat_s(input logic signed [64:0] v);
    res_t r;
    if (v > 65'sh0_7FFF_FFFF) begin
      r.val = 32'h7FFF_FFFF;
      r.sat = 1'b1;
    end else if (v < -65'sh0_8000_0000) begin
      r.val = 32'h8000_0000;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic res_t div_fin(input lane_t l);
    res_t r;
    if (l.neg) begin
      if (l.ovf || l.q > 33'h0_8000_0000) begin
        r.val = 32'h8000_0000;
        r.sat = 1'b1;
      end else begin
        r.val = 32'd0 - l.q[31:0];
        r.sat = 1'b0;
      end
    end else begin
      if (l.ovf || l.q > 33'h0_7FFF_FFFF) begin
        r.val = 32'h7FFF_FFFF;
        r.sat = 1'b1;
      end else begin
        r.val = l.q[31:0];
        r.sat = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/cna_front.sv =====
// Front end: products, sums, saturation and divider setup
module cna_front import cna_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [1:0]         op,
  input  logic signed [31:0] ar,
  input  logic signed [31:0] ai,
  input  logic signed [31:0] br,
  input  logic signed [31:0] bi,
  output pipe_t              head
);

  logic               vld1_r;
  op_t                op1_r;
  logic signed [31:0] ar1_r, ai1_r, br1_r, bi1_r;
  logic signed [63:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, sq_r_r, sq_i_r;
  pipe_t              head_r, head_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
    end
    if (en) begin
      op1_r  <= op_t'(op);
      ar1_r  <= ar;
      ai1_r  <= ai;
      br1_r  <= br;
      bi1_r  <= bi;
      p_rr_r <= ar * br;
      p_ii_r <= ai * bi;
      p_ri_r <= ar * bi;
      p_ir_r <= ai * br;
      sq_r_r <= br * br;
      sq_i_r <= bi * bi;
    end
  end

  function automatic lane_t prep(input logic signed [64:0] s, input logic [63:0] den);
    lane_t              l;
    logic [64:0]        m;
    logic [DVD_W-1:0]   dvd;
    logic [63:0]        top;
    l.neg = s[64];
    m     = s[64] ? (65'd0 - s) : s;
    dvd   = {m[63:0], {FRAC_BITS{1'b0}}};
    top   = {{(64-TOP_W){1'b0}}, dvd[DVD_W-1:QB]};
    l.ovf = (top >= den);
    l.rem = l.ovf ? 64'd0 : top;
    l.lo  = dvd[QB-1:0];
    l.q   = '0;
    return l;
  endfunction

  logic signed [64:0] s_add_r, s_add_i, s_mr, s_mi, s_dr, s_di;
  logic [63:0]        den;
  res_t               x_r, x_i;

  always_comb begin
    s_mr = 65'(p_rr_r) - 65'(p_ii_r);
    s_mi = 65'(p_ri_r) + 65'(p_ir_r);
    s_dr = 65'(p_rr_r) + 65'(p_ii_r);
    s_di = 65'(p_ir_r) - 65'(p_ri_r);
    den  = sq_r_r + sq_i_r;
    if (op1_r == OP_SUB) begin
      s_add_r = 65'(ar1_r) - 65'(br1_r);
      s_add_i = 65'(ai1_r) - 65'(bi1_r);
    end else begin
      s_add_r = 65'(ar1_r) + 65'(br1_r);
      s_add_i = 65'(ai1_r) + 65'(bi1_r);
    end
    if (op1_r == OP_MUL) begin
      x_r = sat_s(s_mr >>> FRAC_BITS);
      x_i = sat_s(s_mi >>> FRAC_BITS);
    end else begin
      x_r = sat_s(s_add_r);
      x_i = sat_s(s_add_i);
    end
    head_nxt.vld    = vld1_r;
    head_nxt.den    = den;
    head_nxt.re     = prep(s_dr, den);
    head_nxt.im     = prep(s_di, den);
    head_nxt.is_div = 1'b0;
    head_nxt.rr     = x_r.val;
    head_nxt.ri     = x_i.val;
    head_nxt.st     = (x_r.sat || x_i.sat) ? ST_SAT : ST_OK;
    if (op1_r == OP_DIV) begin
      if (den == 64'd0) begin
        head_nxt.rr = '0;
        head_nxt.ri = '0;
        head_nxt.st = ST_DIV0;
      end else begin
        head_nxt.is_div = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
    end else if (en) begin
      head_r <= head_nxt;
    end
  end

  assign head = head_r;

endmodule

// ===== rtl/cna_div_cell.sv =====
// Divider cell: one restoring quotient bit per lane, registered
module cna_div_cell import cna_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  pipe_t d,
  output pipe_t q
);

  pipe_t q_r, q_nxt;

  function automatic lane_t step(input lane_t l, input logic [63:0] den);
    lane_t       o;
    logic [63:0] r2;
    o  = l;
    r2 = {l.rem[62:0], l.lo[QB-1]};
    o.lo = {l.lo[QB-2:0], 1'b0};
    if (r2 >= den) begin
      o.rem = r2 - den;
      o.q   = {l.q[QB-2:0], 1'b1};
    end else begin
      o.rem = r2;
      o.q   = {l.q[QB-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    q_nxt    = d;
    q_nxt.re = step(d.re, d.den);
    q_nxt.im = step(d.im, d.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/complex_number_alu.sv =====
// Complex number ALU: add, subtract, multiply, divide in signed Q16.16
// Pipeline: 2 front stages, 33 divider cells and 1 output register, the same
// path for every operation.
// Throughput: one beat per cycle; the whole pipe advances when the output
// register is empty or being taken.
// Reset (synchronous, rst_n low) clears all valid flags; no clearing pass.
module complex_number_alu import cna_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic signed [31:0] in_a_real,
  input  logic signed [31:0] in_a_imag,
  input  logic signed [31:0] in_b_real,
  input  logic signed [31:0] in_b_imag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_result_real,
  output logic signed [31:0] out_result_imag,
  output logic [1:0]  out_status
);

  logic  en;
  pipe_t chain [0:NCELL];
  pipe_t last;
  res_t  f_r, f_i;

  logic        out_valid_r;
  logic [31:0] rr_r, ri_r;
  logic [1:0]  st_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  cna_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .op     (in_operation),
    .ar     (in_a_real),
    .ai     (in_a_imag),
    .br     (in_b_real),
    .bi     (in_b_imag),
    .head   (chain[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    cna_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (chain[g]),
      .q     (chain[g+1])
    );
  end

  assign last = chain[NCELL];

  always_comb begin
    f_r = div_fin(last.re);
    f_i = div_fin(last.im);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.vld;
    end
    if (en) begin
      if (last.is_div) begin
        rr_r <= f_r.val;
        ri_r <= f_i.val;
        st_r <= (f_r.sat || f_i.sat) ? ST_SAT : ST_OK;
      end else begin
        rr_r <= last.rr;
        ri_r <= last.ri;
        st_r <= last.st;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_real = rr_r;
  assign out_result_imag = ri_r;
  assign out_status      = st_r;

endmodule

// ===== rtl/complex_number_alu_sva.sv =====
// Port checker for the complex number ALU, bound to the top level
`include "complex_number_alu_macros.svh"
module complex_number_alu_sva import cna_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_real,
  input logic [31:0] out_result_imag,
  input logic [1:0]  out_status
);

  `CNA_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid)
  `CNA_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_result_real) && $stable(out_result_imag) && $stable(out_status))
  `CNA_ASSERT(a_div0_zero, out_valid && out_status == ST_DIV0 |-> out_result_real == 32'd0 && out_result_imag == 32'd0)
  `CNA_ASSERT(a_status_code, out_valid |-> out_status != ST_RSVD)
  `CNA_ASSERT(a_ready_free, !out_valid |-> in_ready)

endmodule

bind complex_number_alu complex_number_alu_sva u_sva (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_real (out_result_real),
  .out_result_imag (out_result_imag),
  .out_status      (out_status)
);
